[hw/rtl/rfd_pkg.sv]
// Shared constants, types and fixed-point helpers for the RK4 forced-decay step core.
`timescale 1ns / 1ps

package rfd_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STEP  = 2'd0,
        CFG_DECAY = 2'd1,
        CFG_AMP   = 2'd2,
        CFG_FREQ  = 2'd3
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [30:0] STEP_RST  = 31'd655;
    localparam logic [31:0] DECAY_RST = 32'd65536;
    localparam logic [31:0] AMP_RST   = 32'd0;
    localparam logic [31:0] FREQ_RST  = 32'd0;

    // Pipeline depth of the cosine unit and of one slope/k unit
    localparam int COS_LAT = 11;
    localparam int KST_LAT = 5;

    // Two pi in Q16.16, and a multiple of it that lifts any phase above zero
    localparam logic [32:0] TWO_PI_Q   = 33'd411775;
    localparam logic [32:0] PHASE_LIFT = 33'd2147818400;

    // Quarter-wave cosine table
    localparam int COS_DEPTH  = 1024;
    localparam int COS_IDX_W  = 11;
    localparam int COS_FR_W   = 20;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
    localparam logic [63:0] COS_TERM_DEN [1:13] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
        64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650
    };
    typedef logic [16:0] t_cos_tab [0:COS_DEPTH];

    // floor(x/6) = (x * magic) >> 34 for any 32-bit x
    localparam logic [31:0] DIV6_MAGIC = 32'hAAAAAAAB;
    localparam int          DIV6_SHIFT = 34;

    // Saturated value with its overflow flag
    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } t_sat;

    // Magnitude of a signed word, -2^31 maps to 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // Round a magnitude product back to Q16.16, apply sign, saturate
    function automatic t_sat mul_fin(input logic [63:0] p, input logic neg);
        t_sat        res;
        logic [47:0] r;
        logic [47:0] lim;
        r       = 48'((p + 64'd32768) >> 16);
        lim     = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
        res.ovf = (r > lim);
        if (r > lim) begin
            r = lim;
        end
        res.val = neg ? -signed'(r[31:0]) : signed'(r[31:0]);
        return res;
    endfunction

    // Saturating add
    function automatic t_sat sadd(input logic signed [31:0] x, input logic signed [31:0] y);
        t_sat               res;
        logic signed [32:0] s;
        s       = {x[31], x} + {y[31], y};
        res.ovf = (s[32] != s[31]);
        res.val = res.ovf ? (s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : s[31:0];
        return res;
    endfunction

    // Saturating subtract
    function automatic t_sat ssub(input logic signed [31:0] x, input logic signed [31:0] y);
        t_sat               res;
        logic signed [32:0] s;
        s       = {x[31], x} - {y[31], y};
        res.ovf = (s[32] != s[31]);
        res.val = res.ovf ? (s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : s[31:0];
        return res;
    endfunction

    // Halve with rounding to nearest, ties away from zero
    function automatic logic signed [31:0] half(input logic signed [31:0] x);
        logic [31:0] m;
        m = (mag32(x) + 32'd1) >> 1;
        return x[31] ? -signed'(m) : signed'(m);
    endfunction

    // (a*b + 2^(sh-1)) >> sh on a full 128-bit product, for table build only
    function automatic logic [63:0] umul_shr(input logic [63:0] a, input logic [63:0] b,
                                             input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        return 64'(p >> sh);
    endfunction

    // Quarter-wave table: entry k = cos(pi/2 * k/COS_DEPTH) in Q16.16
    function automatic t_cos_tab cos_tab_build();
        t_cos_tab           tab;
        logic [63:0]        fr;
        logic [63:0]        th;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 k;
        int                 n;
        for (k = 0; k <= COS_DEPTH; k++) begin
            fr   = 64'(k) << 36;
            th   = umul_shr(fr, HALF_PI_Q60, 46);
            x2   = umul_shr(th, th, 60);
            term = 64'd1 << 60;
            sum  = signed'(term);
            for (n = 1; n <= 13; n++) begin
                term = umul_shr(term, x2, 60) / COS_TERM_DEN[n];
                if (n % 2 == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            tab[k] = 17'((64'(sum) + (64'd1 << 43)) >> 44);
        end
        return tab;
    endfunction

endpackage

[hw/rtl/rfd_cos.sv]
// Pipelined cosine of omega*t: phase product, reduction mod two pi, table interpolation.
`timescale 1ns / 1ps

module rfd_cos (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_t,
    input  logic signed [31:0] i_w,
    output logic signed [17:0] o_cos,
    output logic               o_ovf
);
    import rfd_pkg::*;

    localparam t_cos_tab COS_TAB = cos_tab_build();

    // Restoring remainder steps over quotient bits hi..lo
    function automatic logic [32:0] mod_steps(input logic [32:0] x, input int hi, input int lo);
        int i;
        for (i = hi; i >= lo; i--) begin
            if (x >= (TWO_PI_Q << i)) begin
                x = x - (TWO_PI_Q << i);
            end
        end
        return x;
    endfunction

    // Eight bits of the turn fraction r * 2^32 / two pi
    function automatic logic [50:0] turn_steps(input logic [18:0] r, input logic [31:0] u);
        logic [19:0] t;
        int          i;
        for (i = 0; i < 8; i++) begin
            t = {r, 1'b0};
            u = {u[30:0], 1'b0};
            if (t >= TWO_PI_Q[19:0]) begin
                t    = t - TWO_PI_Q[19:0];
                u[0] = 1'b1;
            end
            r = t[18:0];
        end
        return {r, u};
    endfunction

    logic [63:0]        r_p;
    logic               r_pn;
    logic signed [31:0] r_ph;
    logic               r_of [2:COS_LAT-1];
    logic [32:0]        r_x;
    logic [32:0]        r_rh;
    logic [18:0]        r_r;
    logic [18:0]        r_dr [0:3];
    logic [31:0]        r_du [0:3];
    logic [16:0]        r_lo;
    logic [16:0]        r_hi;
    logic [COS_FR_W-1:0] r_fr;
    logic               r_ng;

    t_sat                  w_ph;
    logic [50:0]           w_ts [0:3];
    logic [30:0]           w_qq;
    logic [COS_IDX_W-1:0]  w_idx;
    logic [COS_IDX_W-1:0]  w_idx_n;
    logic signed [17:0]    w_d;
    logic [16:0]           w_md;
    logic [36:0]           w_pr;
    logic signed [17:0]    w_m;
    logic signed [17:0]    w_val;

    // Phase rounding and the turn-fraction steps
    always_comb begin
        w_ph    = mul_fin(r_p, r_pn);
        w_ts[0] = turn_steps(r_r, 32'd0);
        for (int s = 1; s < 4; s++) begin
            w_ts[s] = turn_steps(r_dr[s-1], r_du[s-1]);
        end
    end

    // Quadrant fold and table addresses
    always_comb begin
        w_qq    = r_du[3][30] ? (31'h4000_0000 - {1'b0, r_du[3][29:0]})
                              : {1'b0, r_du[3][29:0]};
        w_idx   = w_qq[30:COS_FR_W];
        w_idx_n = (w_idx == COS_IDX_W'(COS_DEPTH)) ? w_idx : w_idx + 1'b1;
    end

    // Linear interpolation between two neighboring entries
    always_comb begin
        w_d   = signed'({1'b0, r_lo}) - signed'({1'b0, r_hi});
        w_md  = w_d[17] ? 17'(-w_d) : w_d[16:0];
        w_pr  = 37'(w_md) * 37'(r_fr) + (37'd1 << (COS_FR_W - 1));
        w_m   = signed'({1'b0, w_pr[36:COS_FR_W]});
        w_val = w_d[17] ? signed'({1'b0, r_lo}) + w_m : signed'({1'b0, r_lo}) - w_m;
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= 64'(mag32(i_w)) * 64'(mag32(i_t));
            r_pn  <= i_w[31] ^ i_t[31];
            r_ph  <= w_ph.val;
            r_of[2] <= w_ph.ovf;
            for (int s = 3; s < COS_LAT; s++) begin
                r_of[s] <= r_of[s-1];
            end
            r_x   <= {r_ph[31], r_ph} + PHASE_LIFT;
            r_rh  <= mod_steps(r_x, 13, 7);
            r_r   <= 19'(mod_steps(r_rh, 6, 0));
            for (int s = 0; s < 4; s++) begin
                r_dr[s] <= w_ts[s][50:32];
                r_du[s] <= w_ts[s][31:0];
            end
            r_lo  <= COS_TAB[w_idx];
            r_hi  <= COS_TAB[w_idx_n];
            r_fr  <= w_qq[COS_FR_W-1:0];
            r_ng  <= r_du[3][31] ^ r_du[3][30];
            o_cos <= r_ng ? -w_val : w_val;
            o_ovf <= r_of[COS_LAT-1];
        end
    end

endmodule

[hw/rtl/rfd_kstage.sv]
// One RK4 increment: k = h * (b*cos - a*y), pipelined over five stages.
`timescale 1ns / 1ps

module rfd_kstage (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [17:0] i_c,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic [30:0]        i_h,
    output logic signed [31:0] o_k,
    output logic               o_ovf
);
    import rfd_pkg::*;

    logic [63:0]        r_pb;
    logic               r_nb;
    logic [63:0]        r_pa;
    logic               r_na;
    logic signed [31:0] r_bc;
    logic signed [31:0] r_ac;
    logic               r_of2;
    logic signed [31:0] r_sl;
    logic               r_of3;
    logic [63:0]        r_ph;
    logic               r_nh;
    logic               r_of4;

    t_sat w_bc;
    t_sat w_ac;
    t_sat w_sl;
    t_sat w_k;

    always_comb begin
        w_bc = mul_fin(r_pb, r_nb);
        w_ac = mul_fin(r_pa, r_na);
        w_sl = ssub(r_bc, r_ac);
        w_k  = mul_fin(r_ph, r_nh);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // forcing and decay products
            r_pb  <= 64'(mag32(i_b)) * 64'(mag32(32'(i_c)));
            r_nb  <= i_b[31] ^ i_c[17];
            r_pa  <= 64'(mag32(i_a)) * 64'(mag32(i_y));
            r_na  <= i_a[31] ^ i_y[31];
            // round both
            r_bc  <= w_bc.val;
            r_ac  <= w_ac.val;
            r_of2 <= w_bc.ovf | w_ac.ovf;
            // slope
            r_sl  <= w_sl.val;
            r_of3 <= r_of2 | w_sl.ovf;
            // scale by the step
            r_ph  <= 64'(i_h) * 64'(mag32(r_sl));
            r_nh  <= r_sl[31];
            r_of4 <= r_of3;
            o_k   <= w_k.val;
            o_ovf <= r_of4 | w_k.ovf;
        end
    end

endmodule

[hw/rtl/rk4_forced_decay_step_core.sv]
// Top level of the RK4 step core for dy/dt = b*cos(omega*t) - a*y.
`timescale 1ns / 1ps

// One item per clock while the output queue has room: each transfer on the input
// stream returns one transfer on the output stream, after 41 pipeline register
// stages plus the output register. The datapath is a fixed 41-stage pipeline;
// three cosine units evaluate the forcing at t, t+h/2 and t+h at the same time,
// and four slope units form k1..k4 in sequence. A two-entry output queue lets the
// pipeline keep taking items while a result waits; the input stalls only once that
// queue is full, and all stages then hold together. Each cosine unit holds a
// 1025-entry quarter-wave ROM read at two addresses per cycle. The overflow flag
// (tuser) marks any saturation inside the step. The user must write configuration
// on its own channel only while the stream is idle; the block does not enforce it.

module rk4_forced_decay_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,    // [31:0] time_now, [63:32] value_now
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [31:0] value_next
    output logic        o_m_tuser,    // [0] overflow
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import rfd_pkg::*;

    // Stage numbers of the main datapath
    localparam int ST_C  = 1 + COS_LAT;
    localparam int ST_K1 = ST_C + KST_LAT;
    localparam int ST_Y2 = ST_K1 + 1;
    localparam int ST_K2 = ST_Y2 + KST_LAT;
    localparam int ST_Y3 = ST_K2 + 1;
    localparam int ST_S1 = ST_Y3 + 1;
    localparam int ST_K3 = ST_Y3 + KST_LAT;
    localparam int ST_Y4 = ST_K3 + 1;
    localparam int ST_S2 = ST_Y4 + 1;
    localparam int ST_K4 = ST_Y4 + KST_LAT;
    localparam int ST_S3 = ST_K4 + 1;
    localparam int ST_O  = ST_S3 + 4;

    // Configuration registers
    logic [30:0]        r_step;
    logic signed [31:0] r_decay;
    logic signed [31:0] r_amp;
    logic signed [31:0] r_freq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RST;
            r_decay <= DECAY_RST;
            r_amp   <= AMP_RST;
            r_freq  <= FREQ_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEP:  r_step  <= i_cfg_data[30:0];
                CFG_DECAY: r_decay <= i_cfg_data;
                CFG_AMP:   r_amp   <= i_cfg_data;
                CFG_FREQ:  r_freq  <= i_cfg_data;
            endcase
        end
    end

    // Pipeline control
    logic w_en;
    logic r_v [0:ST_O];
    logic r_sk_v;

    assign w_en       = !r_sk_v;
    assign o_s_tready = w_en;

    // Datapath registers
    logic signed [31:0] r_t0;
    logic signed [31:0] r_y  [0:ST_O-1];
    logic               r_ovf [1:ST_O];
    logic signed [31:0] r_t1;
    logic signed [31:0] r_tm;
    logic signed [31:0] r_te;
    logic signed [17:0] r_c2 [ST_C+1:ST_Y3];
    logic signed [17:0] r_c3 [ST_C+1:ST_Y4];
    logic signed [31:0] r_k1 [ST_K1+1:ST_Y3];
    logic signed [31:0] r_ya2;
    logic signed [31:0] r_ya3;
    logic signed [31:0] r_ya4;
    logic signed [31:0] r_d2;
    logic signed [31:0] r_d3;
    logic signed [31:0] r_s1 [ST_S1:ST_Y4];
    logic signed [31:0] r_s2 [ST_S2:ST_K4];
    logic signed [31:0] r_s3;
    logic [31:0]        r_m;
    logic               r_mn;
    logic [63:0]        r_pq;
    logic               r_pn;
    logic signed [31:0] r_q;
    logic signed [31:0] r_yn;

    // Unit outputs
    logic signed [17:0] w_cos1, w_cos2, w_cos3;
    logic               w_cov1, w_cov2, w_cov3;
    logic signed [31:0] w_k1, w_k2, w_k3, w_k4;
    logic               w_kov1, w_kov2, w_kov3, w_kov4;

    rfd_cos u_cos1 (.i_clk(i_clk), .i_en(w_en), .i_t(r_t1), .i_w(r_freq),
                    .o_cos(w_cos1), .o_ovf(w_cov1));
    rfd_cos u_cos2 (.i_clk(i_clk), .i_en(w_en), .i_t(r_tm), .i_w(r_freq),
                    .o_cos(w_cos2), .o_ovf(w_cov2));
    rfd_cos u_cos3 (.i_clk(i_clk), .i_en(w_en), .i_t(r_te), .i_w(r_freq),
                    .o_cos(w_cos3), .o_ovf(w_cov3));

    rfd_kstage u_k1 (.i_clk(i_clk), .i_en(w_en), .i_c(w_cos1), .i_y(r_y[ST_C]),
                     .i_a(r_decay), .i_b(r_amp), .i_h(r_step), .o_k(w_k1), .o_ovf(w_kov1));
    rfd_kstage u_k2 (.i_clk(i_clk), .i_en(w_en), .i_c(r_c2[ST_Y2]), .i_y(r_ya2),
                     .i_a(r_decay), .i_b(r_amp), .i_h(r_step), .o_k(w_k2), .o_ovf(w_kov2));
    rfd_kstage u_k3 (.i_clk(i_clk), .i_en(w_en), .i_c(r_c2[ST_Y3]), .i_y(r_ya3),
                     .i_a(r_decay), .i_b(r_amp), .i_h(r_step), .o_k(w_k3), .o_ovf(w_kov3));
    rfd_kstage u_k4 (.i_clk(i_clk), .i_en(w_en), .i_c(r_c3[ST_Y4]), .i_y(r_ya4),
                     .i_a(r_decay), .i_b(r_amp), .i_h(r_step), .o_k(w_k4), .o_ovf(w_kov4));

    // Saturating arithmetic between the units
    logic [31:0] w_hh;
    t_sat w_tm, w_te, w_ya2, w_ya3, w_ya4, w_d2, w_d3, w_s1, w_s2, w_s3, w_yn;
    logic [29:0] w_qm;

    always_comb begin
        w_hh  = ({1'b0, r_step} + 32'd1) >> 1;
        w_tm  = sadd(r_t0, signed'(w_hh));
        w_te  = sadd(r_t0, signed'({1'b0, r_step}));
        w_ya2 = sadd(r_y[ST_K1], half(w_k1));
        w_ya3 = sadd(r_y[ST_K2], half(w_k2));
        w_d2  = sadd(w_k2, w_k2);
        w_s1  = sadd(r_k1[ST_Y3], r_d2);
        w_ya4 = sadd(r_y[ST_K3], w_k3);
        w_d3  = sadd(w_k3, w_k3);
        w_s2  = sadd(r_s1[ST_Y4], r_d3);
        w_s3  = sadd(r_s2[ST_K4], w_k4);
        w_qm  = r_pq[63:DIV6_SHIFT];
        w_yn  = sadd(r_y[ST_O-1], r_q);
    end

    // Next overflow line, with the flags of each stage merged in
    logic w_ovf_in [1:ST_O];

    always_comb begin
        w_ovf_in[1] = w_tm.ovf | w_te.ovf;
        for (int i = 2; i <= ST_O; i++) begin
            w_ovf_in[i] = r_ovf[i-1];
        end
        w_ovf_in[ST_C+1] = r_ovf[ST_C] | w_cov1 | w_cov2 | w_cov3;
        w_ovf_in[ST_Y2]  = r_ovf[ST_K1] | w_kov1 | w_ya2.ovf;
        w_ovf_in[ST_Y3]  = r_ovf[ST_K2] | w_kov2 | w_ya3.ovf | w_d2.ovf;
        w_ovf_in[ST_S1]  = r_ovf[ST_Y3] | w_s1.ovf;
        w_ovf_in[ST_Y4]  = r_ovf[ST_K3] | w_kov3 | w_ya4.ovf | w_d3.ovf;
        w_ovf_in[ST_S2]  = r_ovf[ST_Y4] | w_s2.ovf;
        w_ovf_in[ST_S3]  = r_ovf[ST_K4] | w_kov4 | w_s3.ovf;
        w_ovf_in[ST_O]   = r_ovf[ST_O-1] | w_yn.ovf;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= ST_O; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= i_s_tvalid;
            for (int i = 1; i <= ST_O; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0    <= i_s_tdata[31:0];
            r_y[0]  <= i_s_tdata[63:32];
            for (int i = 1; i < ST_O; i++) begin
                r_y[i] <= r_y[i-1];
            end
            // step times
            r_t1    <= r_t0;
            r_tm    <= w_tm.val;
            r_te    <= w_te.val;
            // overflow line
            for (int i = 1; i <= ST_O; i++) begin
                r_ovf[i] <= w_ovf_in[i];
            end
            // cosine values held for the later slopes
            r_c2[ST_C+1] <= w_cos2;
            for (int i = ST_C + 2; i <= ST_Y3; i++) begin
                r_c2[i] <= r_c2[i-1];
            end
            r_c3[ST_C+1] <= w_cos3;
            for (int i = ST_C + 2; i <= ST_Y4; i++) begin
                r_c3[i] <= r_c3[i-1];
            end
            r_k1[ST_K1+1] <= w_k1;
            for (int i = ST_K1 + 2; i <= ST_Y3; i++) begin
                r_k1[i] <= r_k1[i-1];
            end
            // slope arguments and running sum
            r_ya2 <= w_ya2.val;
            r_ya3 <= w_ya3.val;
            r_d2  <= w_d2.val;
            r_s1[ST_S1] <= w_s1.val;
            for (int i = ST_S1 + 1; i <= ST_Y4; i++) begin
                r_s1[i] <= r_s1[i-1];
            end
            r_ya4 <= w_ya4.val;
            r_d3  <= w_d3.val;
            r_s2[ST_S2] <= w_s2.val;
            for (int i = ST_S2 + 1; i <= ST_K4; i++) begin
                r_s2[i] <= r_s2[i-1];
            end
            r_s3  <= w_s3.val;
            // divide by six, rounded to nearest
            r_m   <= mag32(r_s3) + 32'd3;
            r_mn  <= r_s3[31];
            r_pq  <= 64'(r_m) * 64'(DIV6_MAGIC);
            r_pn  <= r_mn;
            r_q   <= r_pn ? -signed'({2'b00, w_qm}) : signed'({2'b00, w_qm});
            r_yn  <= w_yn.val;
        end
    end

    // Output register and skid entry
    logic        r_o_v;
    logic [32:0] r_o_d;
    logic [32:0] r_sk_d;
    logic        w_push;
    logic        w_pop;
    logic        n_o_v;
    logic        n_sk_v;
    logic        w_ld_o;
    logic        w_ld_sk;
    logic        w_o_from_sk;

    assign w_push = w_en && r_v[ST_O];
    assign w_pop  = r_o_v && i_m_tready;

    always_comb begin
        n_o_v       = r_o_v;
        n_sk_v      = r_sk_v;
        w_ld_o      = 1'b0;
        w_ld_sk     = 1'b0;
        w_o_from_sk = 1'b0;
        priority if (r_sk_v) begin
            if (w_pop) begin
                w_ld_o      = 1'b1;
                w_o_from_sk = 1'b1;
                n_sk_v      = 1'b0;
            end
        end else if (w_push) begin
            if (!r_o_v || w_pop) begin
                w_ld_o = 1'b1;
                n_o_v  = 1'b1;
            end else begin
                w_ld_sk = 1'b1;
                n_sk_v  = 1'b1;
            end
        end else begin
            if (w_pop) begin
                n_o_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else begin
            r_o_v  <= n_o_v;
            r_sk_v <= n_sk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_o) begin
            r_o_d <= w_o_from_sk ? r_sk_d : {r_ovf[ST_O], r_yn};
        end
        if (w_ld_sk) begin
            r_sk_d <= {r_ovf[ST_O], r_yn};
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_d[31:0];
    assign o_m_tuser  = r_o_d[32];

    // The skid entry is only ever behind a held output
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_sk_v |-> r_o_v)
        else $error("skid entry full while output register empty");

    // A result leaving the pipeline always lands in the output queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (w_en && r_v[ST_O]) |=> r_o_v)
        else $error("pipeline result dropped");

    // A full queue that is not drained stays full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (r_sk_v && !i_m_tready) |=> (r_sk_v && r_o_v))
        else $error("queued result lost during stall");

endmodule
